// ===== rtl/cas_pkg.sv =====
`timescale 1ns / 1ps

package cas_pkg;

    localparam int CAS_MAX_COLS = 1024;
    localparam int CAS_MAX_ROWS = 1024;

    localparam int CFG_W   = 11;
    localparam int POS_W   = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // live neighbour count at which a cell keeps its old value
    localparam logic [3:0] KEEP_COUNT = 4'd4;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic ACTION_CELL  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    typedef struct packed {
        logic action;
        logic cell_alive;
    } t_in_word;

    typedef struct packed {
        logic             new_alive;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_out_word;

    // emit position and border flags of the cell that an item completes
    typedef struct packed {
        logic             emit;
        logic             last;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_pos;

endpackage

// ===== rtl/cas_ram.sv =====
`timescale 1ns / 1ps

module cas_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cas_ctrl.sv =====
`timescale 1ns / 1ps

module cas_ctrl #(
    parameter int MAX_ROWS = cas_pkg::CAS_MAX_ROWS,
    parameter int MAX_COLS = cas_pkg::CAS_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [$clog2(MAX_ROWS+3)-1:0] i_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_cols,
    output logic [$clog2(MAX_COLS)-1:0]   o_rd_addr,
    output cas_pkg::t_pos                 o_pos
);

    localparam int RCNT_W = $clog2(MAX_ROWS + 3);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(MAX_COLS);

    logic [RCNT_W-1:0] r_in_row, n_in_row;
    logic [ADDR_W-1:0] r_in_col, n_in_col;
    logic [RCNT_W-1:0] r_emit_row, n_emit_row;
    logic [ADDR_W-1:0] r_emit_col, n_emit_col;

    logic        w_emit;
    logic        w_in_col_end;
    logic        w_row_end;
    logic        w_col_end;
    logic [31:0] w_row_full;
    logic [31:0] w_col_full;

    assign w_emit = (r_in_row >= RCNT_W'(2))
                 || ((r_in_row == RCNT_W'(1)) && (r_in_col != '0));
    assign w_in_col_end = (CCNT_W'(r_in_col) + CCNT_W'(1)) >= i_cols;
    assign w_row_end    = (r_emit_row + RCNT_W'(1)) >= i_rows;
    assign w_col_end    = (CCNT_W'(r_emit_col) + CCNT_W'(1)) >= i_cols;

    assign w_row_full = 32'(r_emit_row);
    assign w_col_full = 32'(r_emit_col);

    always_comb begin
        o_pos.emit   = w_emit;
        o_pos.last   = w_row_end && w_col_end;
        o_pos.top    = (r_emit_row == '0);
        o_pos.bottom = w_row_end;
        o_pos.left   = (r_emit_col == '0);
        o_pos.right  = w_col_end;
        o_pos.row    = w_row_full[cas_pkg::POS_W-1:0];
        o_pos.col    = w_col_full[cas_pkg::POS_W-1:0];
    end

    assign o_rd_addr = r_in_col;

    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_emit_row = r_emit_row;
        n_emit_col = r_emit_col;
        if (i_accept) begin
            if (w_in_col_end) begin
                n_in_col = '0;
                if (r_in_row < RCNT_W'(MAX_ROWS + 2)) begin
                    n_in_row = r_in_row + RCNT_W'(1);
                end
            end else begin
                n_in_col = r_in_col + ADDR_W'(1);
            end
            if (w_emit) begin
                if (o_pos.last) begin
                    // frame done: every position back to the start
                    n_in_row   = '0;
                    n_in_col   = '0;
                    n_emit_row = '0;
                    n_emit_col = '0;
                end else if (w_col_end) begin
                    n_emit_col = '0;
                    n_emit_row = r_emit_row + RCNT_W'(1);
                end else begin
                    n_emit_col = r_emit_col + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_emit_row <= n_emit_row;
            r_emit_col <= n_emit_col;
        end
    end

endmodule

// ===== rtl/cas_win.sv =====
`timescale 1ns / 1ps

module cas_win #(
    parameter int MAX_COLS = cas_pkg::CAS_MAX_COLS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  cas_pkg::t_in_word           i_word,
    input  cas_pkg::t_pos               i_pos,
    input  logic [$clog2(MAX_COLS)-1:0] i_rd_addr,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cas_pkg::t_out_word          o_out_word
);

    localparam int ADDR_W = $clog2(MAX_COLS);

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_v;
    cas_pkg::t_pos     r_s1_pos;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_fwd;
    logic [1:0]        r_s1_fwd_data;

    logic [8:0]         r_window, n_window;
    logic               r_out_valid, n_out_valid;
    cas_pkg::t_out_word r_out_word;

    logic       w_go;
    logic [1:0] w_rdata;
    logic [1:0] w_held;
    logic [1:0] w_wdata;
    logic [2:0] w_column;
    logic [8:0] w_mask;
    logic [3:0] w_count;
    logic       w_alive;

    // stage one moves on unless its word needs the output register and that is full and not taken
    assign w_go = r_s1_valid
               && (!r_s1_pos.emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_go;

    cas_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_COLS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_go),
        .i_waddr (r_s1_addr),
        .i_wdata (w_wdata),
        .i_re    (i_accept),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // a write in the cycle of the read is not seen by the ram output
    assign w_held   = r_s1_fwd ? r_s1_fwd_data : w_rdata;
    assign w_wdata  = {w_held[0], r_s1_v};
    assign w_column = {r_s1_v, w_held[0], w_held[1]};
    assign n_window = {w_column, r_window[8:3]};

    // bit c*3+r of the window, c left to right, r top to bottom
    always_comb begin
        w_mask = 9'h1FF;
        w_mask[4] = 1'b0;
        if (r_s1_pos.left) begin
            w_mask[2:0] = 3'b000;
        end
        if (r_s1_pos.right) begin
            w_mask[8:6] = 3'b000;
        end
        if (r_s1_pos.top) begin
            w_mask[0] = 1'b0;
            w_mask[3] = 1'b0;
            w_mask[6] = 1'b0;
        end
        if (r_s1_pos.bottom) begin
            w_mask[2] = 1'b0;
            w_mask[5] = 1'b0;
            w_mask[8] = 1'b0;
        end
    end

    always_comb begin
        w_count = '0;
        for (int i = 0; i < 9; i++) begin
            w_count = w_count + 4'(n_window[i] & w_mask[i]);
        end
    end

    always_comb begin
        if (w_count < cas_pkg::KEEP_COUNT) begin
            w_alive = 1'b0;
        end else if (w_count > cas_pkg::KEEP_COUNT) begin
            w_alive = 1'b1;
        end else begin
            w_alive = n_window[4];
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_go) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_go && r_s1_pos.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (w_go) begin
                r_window <= n_window;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_v        <= (i_word.action == cas_pkg::ACTION_FLUSH) ? 1'b0
                                                                      : i_word.cell_alive;
            r_s1_pos      <= i_pos;
            r_s1_addr     <= i_rd_addr;
            r_s1_fwd      <= w_go && (r_s1_addr == i_rd_addr);
            r_s1_fwd_data <= w_wdata;
        end
        if (w_go && r_s1_pos.emit) begin
            r_out_word.new_alive  <= w_alive;
            r_out_word.out_row    <= r_s1_pos.row;
            r_out_word.out_col    <= r_s1_pos.col;
            r_out_word.frame_last <= r_s1_pos.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/cave_automaton_step.sv =====
`timescale 1ns / 1ps
// a result word is registered in the output register once the item that completes its
//   neighbourhood (num_cols+1 words behind the cell) has passed stage one
// throughput: one word per cycle, set by the single-port-per-side line store ram;
//   the input stalls only while a full output register is not taken
// reset: i_rst_n synchronous active low; clears positions, window and handshake
//   state, sets num_rows and num_cols to 1024; line store is not cleared
module cave_automaton_step #(
    parameter int MAX_ROWS = cas_pkg::CAS_MAX_ROWS,
    parameter int MAX_COLS = cas_pkg::CAS_MAX_COLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  cas_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cas_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cas_pkg::APB_AW-1:0]   paddr,
    input  logic [cas_pkg::APB_DW-1:0]   pwdata,
    output logic [cas_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int RCNT_W = $clog2(MAX_ROWS + 3);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ADDR_W = $clog2(MAX_COLS);

    logic [cas_pkg::CFG_W-1:0] r_num_rows;
    logic [cas_pkg::CFG_W-1:0] r_num_cols;

    logic              w_cfg_wr;
    logic [31:0]       w_rows_full;
    logic [31:0]       w_cols_full;
    logic [RCNT_W-1:0] w_rows;
    logic [CCNT_W-1:0] w_cols;
    logic              w_accept;
    logic [ADDR_W-1:0] w_rd_addr;
    cas_pkg::t_pos     w_pos;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= cas_pkg::CFG_W'(1024);
            r_num_cols <= cas_pkg::CFG_W'(1024);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                cas_pkg::REG_NUM_ROWS: r_num_rows <= pwdata[cas_pkg::CFG_W-1:0];
                cas_pkg::REG_NUM_COLS: r_num_cols <= pwdata[cas_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cas_pkg::REG_NUM_ROWS: prdata = cas_pkg::APB_DW'(r_num_rows);
            cas_pkg::REG_NUM_COLS: prdata = cas_pkg::APB_DW'(r_num_cols);
            default:               prdata = '0;
        endcase
    end

    // zero behaves as one, anything above the maximum as the maximum
    assign w_rows_full = (r_num_rows == '0) ? 32'd1
                       : (32'(r_num_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                       : 32'(r_num_rows);
    assign w_cols_full = (r_num_cols == '0) ? 32'd1
                       : (32'(r_num_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
                       : 32'(r_num_cols);
    assign w_rows = w_rows_full[RCNT_W-1:0];
    assign w_cols = w_cols_full[CCNT_W-1:0];

    assign w_accept = i_in_valid && o_in_ready;

    cas_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rows    (w_rows),
        .i_cols    (w_cols),
        .o_rd_addr (w_rd_addr),
        .o_pos     (w_pos)
    );

    cas_win #(
        .MAX_COLS (MAX_COLS)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_word      (i_in_word),
        .i_pos       (w_pos),
        .i_rd_addr   (w_rd_addr),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    // the word after the final cell starts a fresh frame at the top left
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_pos.emit && w_pos.last |=> (w_rd_addr == '0) && !w_pos.emit)
        else $error("position not cleared after frame end");

    // the input side only stalls behind a full, blocked output register
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");
`endif

endmodule

// ===== sim/cave_automaton_step_test.sv =====
`timescale 1ns / 1ps

module cave_automaton_step_test;

    localparam int unsigned LINE_LEN = cas_pkg::CAS_MAX_COLS;
    localparam int unsigned ROW_CAP  = cas_pkg::CAS_MAX_ROWS;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    cas_pkg::t_in_word             i_in_word   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    cas_pkg::t_out_word            o_out_word;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [cas_pkg::APB_AW-1:0]    paddr       = '0;
    logic [cas_pkg::APB_DW-1:0]    pwdata      = '0;
    logic [cas_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    // shadow of the block: line store, 3x3 window, positions and registers
    logic [1:0]                    line_bits [LINE_LEN];
    logic [8:0]                    nbhd;
    int unsigned                   in_row_pos, in_col_pos, emit_row_pos, emit_col_pos;
    logic [cas_pkg::CFG_W-1:0]     rows_reg, cols_reg;
    bit                            frame_done;
    cas_pkg::t_out_word            cells_due [$];

    int unsigned                   n_items, n_checked, n_frames;
    bit                            failed;
    bit                            feed_steady, sink_steady;

    cave_automaton_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned grid_extent(logic [cas_pkg::CFG_W-1:0] v,
                                                int unsigned cap);
        if (v == '0) return 1;
        return (v > cap) ? cap : int'(v);
    endfunction

    function automatic bit coin(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // one generation step of the shadow grid for an accepted input word
    task automatic step_grid(input cas_pkg::t_in_word w);
        int unsigned        rows, cols, idx, count;
        logic               v;
        logic [1:0]         held;
        logic [2:0]         column;
        bit                 emit_now;
        cas_pkg::t_out_word res_word;
        rows = grid_extent(rows_reg, ROW_CAP);
        cols = grid_extent(cols_reg, LINE_LEN);
        v = (w.action == cas_pkg::ACTION_FLUSH) ? 1'b0 : w.cell_alive;
        idx = (in_col_pos < LINE_LEN) ? in_col_pos : LINE_LEN - 1;
        held = line_bits[idx];
        // top of the column is the cell two rows up
        column = {v, held[0], held[1]};
        emit_now = in_row_pos >= 2 || (in_row_pos == 1 && in_col_pos >= 1);
        line_bits[idx] = {held[0], v};
        nbhd = {column, nbhd[8:3]};

        if (in_col_pos + 1 >= cols) begin
            in_col_pos = 0;
            if (in_row_pos < ROW_CAP + 2) in_row_pos++;
        end else begin
            in_col_pos++;
        end
        if (!emit_now) return;

        count = 0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (c == 0 && emit_col_pos == 0) continue;
                if (c == 2 && emit_col_pos + 1 >= cols) continue;
                if (r == 0 && emit_row_pos == 0) continue;
                if (r == 2 && emit_row_pos + 1 >= rows) continue;
                if (c == 1 && r == 1) continue;
                count += nbhd[c*3 + r];
            end
        end
        if (count < cas_pkg::KEEP_COUNT) begin
            res_word.new_alive = 1'b0;
        end else if (count > cas_pkg::KEEP_COUNT) begin
            res_word.new_alive = 1'b1;
        end else begin
            res_word.new_alive = nbhd[4];
        end
        res_word.out_row    = cas_pkg::POS_W'(emit_row_pos);
        res_word.out_col    = cas_pkg::POS_W'(emit_col_pos);
        res_word.frame_last = (emit_row_pos + 1 >= rows) && (emit_col_pos + 1 >= cols);
        cells_due.push_back(res_word);

        if (res_word.frame_last) begin
            in_row_pos   = 0;
            in_col_pos   = 0;
            emit_row_pos = 0;
            emit_col_pos = 0;
            frame_done   = 1'b1;
        end else if (emit_col_pos + 1 >= cols) begin
            emit_col_pos = 0;
            emit_row_pos++;
        end else begin
            emit_col_pos++;
        end
    endtask

    task automatic send_word(input logic action, input logic alive);
        cas_pkg::t_in_word w;
        int unsigned       gap;
        w.action     = action;
        w.cell_alive = alive;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        step_grid(w);
        n_items++;
        gap = feed_steady ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // input quiet, every expected word back, pipeline given time to empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [cas_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cas_pkg::REG_NUM_ROWS) begin
            rows_reg = value;
        end else begin
            cols_reg = value;
        end
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [cas_pkg::CFG_W-1:0] rows,
                            input logic [cas_pkg::CFG_W-1:0] cols);
        settle();
        write_reg(cas_pkg::REG_NUM_ROWS, rows);
        write_reg(cas_pkg::REG_NUM_COLS, cols);
        frame_done = 1'b0;
    endtask

    // trailing positions; a cell word here lies beyond the grid and is ignored
    task automatic flush_out(input int unsigned noise_pct);
        while (!frame_done) begin
            send_word(coin(noise_pct) ? cas_pkg::ACTION_CELL : cas_pkg::ACTION_FLUSH,
                      1'($urandom_range(0, 1)));
        end
        n_frames++;
    endtask

    task automatic run_grid(input int unsigned fill_pct, input int unsigned noise_pct);
        int unsigned cells;
        cells = grid_extent(rows_reg, ROW_CAP) * grid_extent(cols_reg, LINE_LEN);
        for (int unsigned k = 0; k < cells && !frame_done; k++) begin
            send_word(coin(noise_pct) ? cas_pkg::ACTION_FLUSH : cas_pkg::ACTION_CELL,
                      coin(fill_pct));
        end
        flush_out(noise_pct);
    endtask

    task automatic send_pattern(input logic [8:0] alive_bits, input logic [8:0] flush_bits,
                                input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            send_word(flush_bits[k] ? cas_pkg::ACTION_FLUSH : cas_pkg::ACTION_CELL,
                      alive_bits[k]);
        end
        flush_out(0);
    endtask

    // zero rows acts as one, oversized column count does not wrap the line early
    task automatic test_wide_row();
        feed_steady = 1'b1;
        sink_steady = 1'b0;
        set_grid(11'd0, 11'h7FF);
        for (int k = 0; k < 40; k++) send_word(cas_pkg::ACTION_CELL, coin(50));
        settle();
        write_reg(cas_pkg::REG_NUM_COLS, 11'd6);
        flush_out(5);
    endtask

    task automatic test_single_cell();
        feed_steady = 1'b0;
        set_grid(11'd1, 11'd0);
        send_pattern(9'h001, 9'h000, 1);
    endtask

    task automatic test_rule_cases();
        set_grid(11'd3, 11'd3);
        // top row and left half of the middle row live: centre sees four, keeps its value
        send_pattern(9'h01F, 9'h000, 9);
        // centre dead with five live neighbours, last word a flush carrying a live bit
        set_grid(11'd3, 11'd3);
        send_pattern(9'h12F, 9'h100, 9);
    endtask

    // shrink the grid while the frame is in flight
    task automatic test_midframe_resize();
        set_grid(11'd5, 11'd5);
        for (int k = 0; k < 14; k++) send_word(cas_pkg::ACTION_CELL, coin(60));
        settle();
        write_reg(cas_pkg::REG_NUM_COLS, 11'd3);
        write_reg(cas_pkg::REG_NUM_ROWS, 11'd2);
        flush_out(20);
    endtask

    // oversized row count runs a single column at the maximum height, then cut short
    task automatic test_tall_column();
        feed_steady = 1'b0;
        sink_steady = 1'b1;
        set_grid(11'h7FF, 11'd1);
        for (int k = 0; k < 48; k++) send_word(cas_pkg::ACTION_CELL, coin(50));
        settle();
        write_reg(cas_pkg::REG_NUM_ROWS, 11'd52);
        flush_out(5);
        sink_steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned               start, pick, fill, noise, span;
        logic [cas_pkg::CFG_W-1:0] rows, cols;
        start = n_items;
        while (n_items - start < 450) begin
            pick = $urandom_range(0, 99);
            rows = (pick < 80) ? cas_pkg::CFG_W'($urandom_range(0, 8))
                               : cas_pkg::CFG_W'($urandom_range(1, 24));
            cols = (pick < 80) ? cas_pkg::CFG_W'($urandom_range(0, 8))
                               : cas_pkg::CFG_W'($urandom_range(1, 24));
            fill = coin(20) ? $urandom_range(0, 100) : $urandom_range(35, 65);
            noise = coin(30) ? $urandom_range(1, 20) : 0;
            feed_steady = coin(20);
            sink_steady = coin(20);
            set_grid(rows, cols);
            if (coin(10)) begin
                span = grid_extent(rows, ROW_CAP) * grid_extent(cols, LINE_LEN)
                       + grid_extent(cols, LINE_LEN);
                span = $urandom_range(1, span);
                for (int unsigned k = 0; k < span && !frame_done; k++) begin
                    send_word(coin(noise) ? cas_pkg::ACTION_FLUSH : cas_pkg::ACTION_CELL,
                              coin(fill));
                end
                if (!frame_done) begin
                    settle();
                    write_reg(coin(50) ? cas_pkg::REG_NUM_ROWS : cas_pkg::REG_NUM_COLS,
                              cas_pkg::CFG_W'($urandom_range(1, 8)));
                end
                flush_out(noise);
            end else begin
                run_grid(fill, noise);
            end
        end
        feed_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        cas_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cells_due.size() == 0) begin
                $error("unexpected result word: row %0d col %0d",
                       o_out_word.out_row, o_out_word.out_col);
                failed = 1'b1;
            end else begin
                want = cells_due.pop_front();
                n_checked++;
                if (o_out_word.new_alive !== want.new_alive) begin
                    $error("new_alive: expected %0d, actual %0d",
                           want.new_alive, o_out_word.new_alive);
                    failed = 1'b1;
                end
                if (o_out_word.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, actual %0d", want.out_row, o_out_word.out_row);
                    failed = 1'b1;
                end
                if (o_out_word.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, actual %0d", want.out_col, o_out_word.out_col);
                    failed = 1'b1;
                end
                if (o_out_word.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, actual %0d",
                           want.frame_last, o_out_word.frame_last);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver side back-pressure
    initial begin
        int unsigned stall;
        forever begin
            @(posedge i_clk);
            stall = sink_steady ? 0 : idle_len();
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        for (int k = 0; k < LINE_LEN; k++) line_bits[k] = 2'b00;
        nbhd         = '0;
        in_row_pos   = 0;
        in_col_pos   = 0;
        emit_row_pos = 0;
        emit_col_pos = 0;
        rows_reg     = cas_pkg::CFG_W'(ROW_CAP);
        cols_reg     = cas_pkg::CFG_W'(LINE_LEN);
        frame_done   = 1'b0;
        failed       = 1'b0;
        feed_steady  = 1'b0;
        sink_steady  = 1'b0;
        n_items      = 0;
        n_checked    = 0;
        n_frames     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_wide_row();
        test_single_cell();
        test_rule_cases();
        test_midframe_resize();
        test_tall_column();
        test_random_frames();

        settle();
        repeat (8) @(posedge i_clk);
        if (cells_due.size() != 0) begin
            $error("%0d expected result words never arrived", cells_due.size());
        end

        $display("%0d input words in %0d frames, %0d result words checked",
                 n_items, n_frames, n_checked);
        $display("grids from a single cell to oversized rows and columns, resized mid-frame");
        if (!failed && cells_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cas_pkg.sv
rtl/cas_ram.sv
rtl/cas_ctrl.sv
rtl/cas_win.sv
rtl/cave_automaton_step.sv
sim/cave_automaton_step_test.sv
